// ----- design/lcfr_pkg.sv -----
`default_nettype none
package lcfr_pkg;

  localparam int unsigned DATA_BYTES  = 8;
  localparam int unsigned REPLY_BYTES = 11;
  localparam int unsigned REPLY_SLOTS = 16;  // reply table row length; a reply sends the first REPLY_BYTES
  localparam int unsigned IDX_W       = $clog2(REPLY_SLOTS);
  localparam int unsigned SEL_W       = 3;
  localparam int unsigned DELAY_W     = 7;
  localparam int unsigned CNT_W       = 4;

  localparam logic [7:0] HDR_A = 8'hFF;
  localparam logic [7:0] HDR_B = 8'hF0;

  localparam logic [7:0] CMD_STATUS  = 8'hA2;
  localparam logic [7:0] CMD_ON_A    = 8'h30;
  localparam logic [7:0] CMD_ON_B    = 8'h31;
  localparam logic [7:0] CMD_BLINK   = 8'h42;
  localparam logic [7:0] CMD_QUERY   = 8'hA0;
  localparam logic [7:0] CMD_PING    = 8'h5F;
  localparam logic [7:0] CMD_UNLOCK  = 8'hCF;
  localparam logic [7:0] CMD_LOCK    = 8'hBD;

  localparam logic [DELAY_W-1:0] DELAY_SHORT = DELAY_W'(10);
  localparam logic [DELAY_W-1:0] DELAY_MID   = DELAY_W'(15);
  localparam logic [DELAY_W-1:0] DELAY_LONG  = DELAY_W'(89);

  localparam logic LED_ON    = 1'b0;
  localparam logic LED_BLINK = 1'b1;

  localparam logic KIND_TX  = 1'b0;
  localparam logic KIND_LED = 1'b1;

  localparam logic REQ_BYTE = 1'b0;
  localparam logic REQ_TICK = 1'b1;

  typedef enum logic [3:0] {
    PH_IDLE = 4'b0001,
    PH_CMD  = 4'b0010,
    PH_ID   = 4'b0100,
    PH_DATA = 4'b1000
  } phase_e;

  // one pending output job: an LED result or a reply burst
  typedef struct packed {
    logic             led;
    logic             led_mode;
    logic [SEL_W-1:0] sel;
  } job_t;

  localparam logic [7:0] REPLY_TABLE [8][REPLY_SLOTS] = '{
    '{8'hA3, 8'hAA, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
      8'h00, 8'h00, 8'h4D, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h34, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
      8'h00, 8'h00, 8'h34, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h80, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
      8'h00, 8'h00, 8'h80, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'hA1, 8'hAA, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
      8'h00, 8'h00, 8'h4B, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h5E, 8'h00, 8'h5F, 8'hE0, 8'h00, 8'h00, 8'h00, 8'h00,
      8'h00, 8'h00, 8'h9D, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'hCC, 8'h01, 8'hCF, 8'h53, 8'h36, 8'h2A, 8'h7A, 8'h05,
      8'hF0, 8'hFE, 8'hBC, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'hCB, 8'h02, 8'hCF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
      8'h00, 8'h00, 8'h9C, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h7F, 8'h00, 8'hBD, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
      8'h00, 8'h00, 8'h3C, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
  };

endpackage
`default_nettype wire

// ----- design/lcfr_if.sv -----
`default_nettype none
interface lcfr_in_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [7:0] rx_byte;

  modport source (output valid, output req_type, output rx_byte, input ready);
  modport sink (input valid, input req_type, input rx_byte, output ready);
endinterface

interface lcfr_out_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] tx_byte;
  logic       led_mode;
  logic       last;

  modport source (output valid, output kind, output tx_byte, output led_mode,
                  output last, input ready);
  modport sink (input valid, input kind, input tx_byte, input led_mode,
                input last, output ready);
endinterface
`default_nettype wire

// ----- design/lock_command_frame_responder.sv -----
// Flow: an accepted item is registered in v1_q and decoded there; its result is
// registered in job_q and offered on the output. Throughput: one item per cycle
// while results can enter the output; a reply burst occupies the output for
// REPLY_BYTES transfers, during which only items that cause no result move on.
// Reset (async, active low) returns the parser to idle and drops any pending reply.
`default_nettype none
module lock_command_frame_responder (
  input  wire         clk_i,
  input  wire         rst_ni,
  lcfr_in_if.sink     req_i,
  lcfr_out_if.source  rsp_o
);
  import lcfr_pkg::*;

  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(REPLY_BYTES - 1);

  logic             v1_q;
  logic             type1_q;
  logic [7:0]       byte1_q;

  logic             job_v_q;
  job_t             job_q;
  logic [IDX_W-1:0] idx_q;

  logic             prod;
  job_t             job_new;
  logic             commit;
  logic             out_fire;
  logic             out_last;
  logic             job_free;
  logic             in_fire;

  lcfr_parser u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (v1_q),
    .req_type_i   (type1_q),
    .rx_byte_i    (byte1_q),
    .commit_i     (commit),
    .job_valid_o  (prod),
    .job_o        (job_new)
  );

  assign out_last = job_q.led || (idx_q == IDX_LAST);
  assign out_fire = job_v_q && rsp_o.ready;
  assign job_free = !job_v_q || (out_fire && out_last);
  // items that cause no result may pass a busy output
  assign commit   = v1_q && (job_free || !prod);
  assign req_i.ready = !v1_q || commit;
  assign in_fire  = req_i.valid && req_i.ready;

  assign rsp_o.valid    = job_v_q;
  assign rsp_o.kind     = job_q.led ? KIND_LED : KIND_TX;
  assign rsp_o.tx_byte  = job_q.led ? 8'h00 : REPLY_TABLE[job_q.sel][idx_q];
  assign rsp_o.led_mode = job_q.led ? job_q.led_mode : 1'b0;
  assign rsp_o.last     = out_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (in_fire) begin
      v1_q <= 1'b1;
    end else if (commit) begin
      v1_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      type1_q <= req_i.req_type;
      byte1_q <= req_i.rx_byte;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      job_v_q <= 1'b0;
      idx_q   <= '0;
    end else if (commit && prod) begin
      job_v_q <= 1'b1;
      idx_q   <= '0;
    end else if (out_fire && out_last) begin
      job_v_q <= 1'b0;
    end else if (out_fire) begin
      idx_q <= idx_q + IDX_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit && prod) begin
      job_q <= job_new;
    end
  end

endmodule
`default_nettype wire

// ----- design/lcfr_parser.sv -----
`default_nettype none
module lcfr_parser (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              item_valid_i,
  input  wire              req_type_i,
  input  wire [7:0]        rx_byte_i,
  input  wire              commit_i,
  output logic             job_valid_o,
  output lcfr_pkg::job_t   job_o
);
  import lcfr_pkg::*;

  phase_e               phase_q, phase_d;
  logic [7:0]           cmd_q, cmd_d;
  logic                 id1_q, id1_d;
  logic [7:0]           sum_q, sum_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic                 pend_q, pend_d;
  logic [DELAY_W-1:0]   delay_q, delay_d;
  logic [SEL_W-1:0]     sel_q, sel_d;

  logic [DELAY_W-1:0]   delay_dec;
  logic                 known;
  logic                 has_led;
  logic                 led_val;
  logic [SEL_W-1:0]     new_sel;
  logic [DELAY_W-1:0]   new_delay;

  // command decode
  always_comb begin
    known     = 1'b1;
    has_led   = 1'b0;
    led_val   = LED_ON;
    new_sel   = '0;
    new_delay = DELAY_SHORT;
    case (cmd_q)
      CMD_STATUS: new_sel = SEL_W'(0);
      CMD_ON_A, CMD_ON_B: begin
        new_sel = SEL_W'(1);
        has_led = 1'b1;
      end
      CMD_BLINK: begin
        new_sel = SEL_W'(2);
        has_led = 1'b1;
        led_val = LED_BLINK;
      end
      CMD_QUERY: begin
        new_sel   = SEL_W'(3);
        new_delay = DELAY_MID;
      end
      CMD_PING: new_sel = SEL_W'(4);
      CMD_UNLOCK: begin
        new_sel   = id1_q ? SEL_W'(5) : SEL_W'(6);
        new_delay = DELAY_LONG;
        has_led   = 1'b1;
      end
      CMD_LOCK: begin
        new_sel   = SEL_W'(7);
        new_delay = DELAY_LONG;
        has_led   = 1'b1;
        led_val   = LED_BLINK;
      end
      default: known = 1'b0;
    endcase
  end

  assign delay_dec = (delay_q != '0) ? delay_q - DELAY_W'(1) : delay_q;

  always_comb begin
    phase_d     = phase_q;
    cmd_d       = cmd_q;
    id1_d       = id1_q;
    sum_d       = sum_q;
    cnt_d       = cnt_q;
    pend_d      = pend_q;
    delay_d     = delay_q;
    sel_d       = sel_q;
    job_valid_o = 1'b0;
    job_o       = '0;
    if (req_type_i == REQ_TICK) begin
      if (pend_q) begin
        delay_d = delay_dec;
        if (delay_dec == '0) begin
          pend_d      = 1'b0;
          job_valid_o = item_valid_i;
          job_o.sel   = sel_q;
        end
      end
    end else begin
      case (phase_q)
        PH_IDLE: begin
          if (rx_byte_i == HDR_A || rx_byte_i == HDR_B) phase_d = PH_CMD;
        end
        PH_CMD: begin
          cmd_d   = rx_byte_i;
          sum_d   = rx_byte_i;
          phase_d = PH_ID;
        end
        PH_ID: begin
          id1_d   = (rx_byte_i == 8'd1);
          sum_d   = sum_q + rx_byte_i;
          cnt_d   = '0;
          phase_d = PH_DATA;
        end
        PH_DATA: begin
          if (cnt_q < CNT_W'(DATA_BYTES)) begin
            sum_d = sum_q + rx_byte_i;
            cnt_d = cnt_q + CNT_W'(1);
          end else begin
            phase_d = PH_IDLE;
            if (sum_q == rx_byte_i && known) begin
              pend_d  = 1'b1;
              sel_d   = new_sel;
              delay_d = new_delay;
              if (has_led) begin
                job_valid_o    = item_valid_i;
                job_o.led      = 1'b1;
                job_o.led_mode = led_val;
              end
            end
          end
        end
        default: phase_d = PH_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      cmd_q   <= '0;
      id1_q   <= 1'b0;
      sum_q   <= '0;
      cnt_q   <= '0;
      pend_q  <= 1'b0;
      delay_q <= '0;
      sel_q   <= '0;
    end else if (commit_i) begin
      phase_q <= phase_d;
      cmd_q   <= cmd_d;
      id1_q   <= id1_d;
      sum_q   <= sum_d;
      cnt_q   <= cnt_d;
      pend_q  <= pend_d;
      delay_q <= delay_d;
      sel_q   <= sel_d;
    end
  end

endmodule
`default_nettype wire
